// ===== rtl/frmp_pkg.sv =====
// shared types, constants and datapath operation codes for the frame rate monitor
package frmp_pkg;

    localparam int WINDOW_DEF  = 30;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 10;
    localparam int STEPS_W     = 6;
    localparam int MS_PER_SEC  = 1000;

    typedef struct packed {
        logic              mode;
        logic [TIME_W-1:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [RATE_W-1:0] rate_fps;
        logic [TIME_W-1:0] last_duration_ms;
        logic [RATE_W-1:0] wait_ms;
    } t_out;

    // operation the controller asks of the datapath in one cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_BEGIN,
        OP_READ,
        OP_UPDATE,
        OP_AVG_START,
        OP_AVG_ZERO,
        OP_RATE_START,
        OP_RATE_ZERO,
        OP_BUDGET_START,
        OP_BUDGET_ZERO,
        OP_PACE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic is_end;
        logic has_start;
        logic count_nz;
        logic avg_nz;
        logic target_nz;
        logic div_done;
    } t_stat;

endpackage

// ===== rtl/frame_rate_monitor_pacer.sv =====
// frame rate monitor and pacer: frame begin/end events in, rate and pacing wait out
//
// input channel: i_in_valid / o_in_stall carry one event request (mode, now_ms)
// output channel: o_out_valid / i_out_stall carry one result per event
// configuration: i_cfg_we writes the target frame rate from i_cfg_wdata at any
//   edge; zero turns pacing off
// path: a begin event is latched, applied and emitted to the output register;
//   an end event runs through a ring read/update, then up to three divisions
//   on one shared bit-serial divider (32 steps for the average, 10 each for
//   rate and budget), then the pacing update and the output register
// throughput: one event at a time, limited by the shared divider; the next
//   event is taken as soon as the previous result sits in the output register
// reset clears the ring valid bits, sums, start time, rate and target at once,
//   so no clearing sweep is needed
// while the receiver stalls the result holds; a finished event then waits in
//   its last state and no new request is taken until the output frees up
module frame_rate_monitor_pacer #(
    parameter int WINDOW = frmp_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  frmp_pkg::t_in               i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output frmp_pkg::t_out              o_out,
    input  logic                        i_cfg_we,
    input  logic [frmp_pkg::RATE_W-1:0] i_cfg_wdata
);
    import frmp_pkg::*;

    t_op   op;
    t_stat stat;

    frmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_op        (op)
    );

    frmp_datapath #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .o_stat      (stat),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/frmp_div.sv =====
// restoring divider, one quotient bit per cycle, step count chosen per request
module frmp_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [frmp_pkg::TIME_W-1:0]  i_dividend,
    input  logic [frmp_pkg::TIME_W-1:0]  i_divisor,
    input  logic [frmp_pkg::STEPS_W-1:0] i_steps,
    output logic                         o_done,
    output logic [frmp_pkg::TIME_W-1:0]  o_quo
);
    import frmp_pkg::*;

    logic               r_busy;
    logic               r_done;
    logic [STEPS_W-1:0] r_cnt;
    logic [TIME_W-1:0]  r_rem;
    logic [TIME_W-1:0]  r_quo;
    logic [TIME_W-1:0]  r_divisor;

    logic [TIME_W:0]    n_rem_sh;
    logic [TIME_W:0]    n_diff;
    logic               n_ge;

    assign n_rem_sh = {r_rem, r_quo[TIME_W-1]};
    assign n_diff   = n_rem_sh - {1'b0, r_divisor};
    assign n_ge     = n_rem_sh >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEPS_W'(1);
                if (r_cnt == STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend is aligned so its top used bit enters first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend << (STEPS_W'(TIME_W) - i_steps);
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[TIME_W-1:0] : n_rem_sh[TIME_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/frmp_datapath.sv =====
// datapath: duration ring, running sums, divider and result register
module frmp_datapath #(
    parameter int WINDOW = frmp_pkg::WINDOW_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  frmp_pkg::t_op               i_op,
    output frmp_pkg::t_stat             o_stat,
    input  frmp_pkg::t_in               i_in,
    input  logic                        i_cfg_we,
    input  logic [frmp_pkg::RATE_W-1:0] i_cfg_wdata,
    output frmp_pkg::t_out              o_out
);
    import frmp_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef enum logic [1:0] {
        DST_AVG,
        DST_RATE,
        DST_BUDGET
    } t_dst;

    logic [TIME_W-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0] r_ring_vld;
    logic [SLOT_W-1:0] r_slot;
    logic [TIME_W-1:0] r_rd_data;
    logic              r_rd_vld;

    logic              r_mode;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_total;
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_last;
    logic [RATE_W-1:0] r_rate;
    logic [TIME_W-1:0] r_avg;
    logic [RATE_W-1:0] r_budget;
    logic [RATE_W-1:0] r_wait;
    logic [RATE_W-1:0] r_target;
    t_dst              r_dst;
    t_out              r_out;

    logic               n_div_start;
    logic [TIME_W-1:0]  n_dividend;
    logic [TIME_W-1:0]  n_divisor;
    logic [STEPS_W-1:0] n_steps;
    logic               div_done;
    logic [TIME_W-1:0]  div_quo;

    logic [TIME_W-1:0] n_elapsed;
    logic [TIME_W-1:0] n_old;
    logic [CNT_W-1:0]  n_count;
    logic [RATE_W-1:0] n_wait;

    frmp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .i_steps    (n_steps),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    // elapsed time doubles as the measured duration when a start is held
    assign n_elapsed = r_now - r_start;
    assign n_old     = r_rd_vld ? r_rd_data : '0;
    assign n_count   = r_count - CNT_W'(n_old != '0) + CNT_W'(n_elapsed != '0);
    assign n_wait    = ({{(TIME_W-RATE_W){1'b0}}, r_budget} > n_elapsed)
                     ? (r_budget - n_elapsed[RATE_W-1:0]) : '0;

    always_comb begin
        n_div_start = 1'b0;
        n_dividend  = TIME_W'(MS_PER_SEC);
        n_divisor   = r_avg;
        n_steps     = STEPS_W'(RATE_W);
        case (i_op)
            OP_AVG_START: begin
                n_div_start = 1'b1;
                n_dividend  = r_total;
                n_divisor   = TIME_W'(r_count);
                n_steps     = STEPS_W'(TIME_W);
            end
            OP_RATE_START: begin
                n_div_start = 1'b1;
            end
            OP_BUDGET_START: begin
                n_div_start = 1'b1;
                n_divisor   = TIME_W'(r_target);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
            r_slot     <= '0;
            r_start    <= '0;
            r_total    <= '0;
            r_count    <= '0;
            r_last     <= '0;
            r_rate     <= '0;
            r_target   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target <= i_cfg_wdata;
            end
            if (div_done && r_dst == DST_RATE) begin
                r_rate <= div_quo[RATE_W-1:0];
            end
            case (i_op)
                OP_BEGIN: begin
                    if (r_start == '0) begin
                        r_start <= r_now;
                    end
                end
                OP_UPDATE: begin
                    r_ring_vld[r_slot] <= 1'b1;
                    r_slot  <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
                    r_total <= r_total - n_old + n_elapsed;
                    r_count <= n_count;
                    r_last  <= n_elapsed;
                end
                OP_RATE_ZERO: begin
                    r_rate <= '0;
                end
                OP_PACE: begin
                    r_start <= r_now + TIME_W'(n_wait);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == OP_UPDATE) begin
            r_mem[r_slot] <= n_elapsed;
        end
        if (i_op == OP_READ) begin
            r_rd_data <= r_mem[r_slot];
            r_rd_vld  <= r_ring_vld[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_done) begin
            case (r_dst)
                DST_AVG:    r_avg    <= div_quo;
                DST_BUDGET: r_budget <= div_quo[RATE_W-1:0];
                default: begin
                end
            endcase
        end
        case (i_op)
            OP_LATCH: begin
                r_mode <= i_in.mode;
                r_now  <= i_in.now_ms;
            end
            OP_BEGIN:        r_wait   <= '0;
            OP_AVG_START:    r_dst    <= DST_AVG;
            OP_AVG_ZERO:     r_avg    <= '0;
            OP_RATE_START:   r_dst    <= DST_RATE;
            OP_BUDGET_START: r_dst    <= DST_BUDGET;
            OP_BUDGET_ZERO:  r_budget <= '0;
            OP_PACE:         r_wait   <= n_wait;
            OP_EMIT: begin
                r_out.rate_fps         <= r_rate;
                r_out.last_duration_ms <= r_last;
                r_out.wait_ms          <= r_wait;
            end
            default: begin
            end
        endcase
    end

    assign o_stat.is_end    = r_mode;
    assign o_stat.has_start = r_start != '0;
    assign o_stat.count_nz  = r_count != '0;
    assign o_stat.avg_nz    = r_avg != '0;
    assign o_stat.target_nz = r_target != '0;
    assign o_stat.div_done  = div_done;
    assign o_out            = r_out;

endmodule

// ===== rtl/frmp_ctrl.sv =====
// controller: sequences one request through the datapath and owns the handshakes
module frmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  frmp_pkg::t_stat i_stat,
    output frmp_pkg::t_op   o_op
);
    import frmp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UPDATE,
        S_AVG,
        S_AVG_WAIT,
        S_RATE,
        S_RATE_WAIT,
        S_BUDGET,
        S_BUDGET_WAIT,
        S_PACE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_LATCH;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (!i_stat.is_end) begin
                    o_op    = OP_BEGIN;
                    n_state = S_DONE;
                end else if (i_stat.has_start) begin
                    o_op    = OP_READ;
                    n_state = S_UPDATE;
                end else begin
                    n_state = S_BUDGET;
                end
            end
            S_UPDATE: begin
                o_op    = OP_UPDATE;
                n_state = S_AVG;
            end
            S_AVG: begin
                o_op    = i_stat.count_nz ? OP_AVG_START : OP_AVG_ZERO;
                n_state = i_stat.count_nz ? S_AVG_WAIT : S_RATE;
            end
            S_AVG_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_RATE;
                end
            end
            S_RATE: begin
                o_op    = i_stat.avg_nz ? OP_RATE_START : OP_RATE_ZERO;
                n_state = i_stat.avg_nz ? S_RATE_WAIT : S_BUDGET;
            end
            S_RATE_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_BUDGET;
                end
            end
            S_BUDGET: begin
                o_op    = i_stat.target_nz ? OP_BUDGET_START : OP_BUDGET_ZERO;
                n_state = i_stat.target_nz ? S_BUDGET_WAIT : S_PACE;
            end
            S_BUDGET_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_PACE;
                end
            end
            S_PACE: begin
                o_op    = OP_PACE;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_op    = OP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
